### sv/bpg_pkg.sv
// shared types and constants for the beep pattern generator
package bpg_pkg;

  localparam int FIELD_W        = 16;
  localparam int TIME_WIDTH_DEF = 16;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] on_ticks;
    logic [FIELD_W-1:0] off_ticks;
    logic [FIELD_W-1:0] repeat_count;
  } bpg_cmd_t;

  typedef struct packed {
    logic buzzer_on;
    logic busy_res;
    logic start_accepted;
  } bpg_stat_t;

endpackage

### sv/bpg_timer.sv
// pattern timer state and per-item next-state logic
module bpg_timer #(
  parameter int TIME_WIDTH = bpg_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bpg_pkg::bpg_cmd_t cmd,
  output bpg_pkg::bpg_stat_t stat
);
  import bpg_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [TIME_WIDTH:0]   tick_counter, tick_counter_next;
  logic [TIME_WIDTH-1:0] cycles_left, cycles_left_next;
  logic [TIME_WIDTH-1:0] on_limit, on_limit_next;
  logic [TIME_WIDTH:0]   period_limit, period_limit_next;
  logic                  buzzer_level, buzzer_level_next;
  logic                  accepted;

  logic [TIME_WIDTH-1:0] on_t, off_t, count_t;
  logic [TIME_WIDTH:0]   counter_inc;

  assign on_t        = TIME_WIDTH'(cmd.on_ticks);
  assign off_t       = TIME_WIDTH'(cmd.off_ticks);
  assign count_t     = TIME_WIDTH'(cmd.repeat_count);
  assign counter_inc = tick_counter + 1'b1;

  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    cycles_left_next  = cycles_left;
    on_limit_next     = on_limit;
    period_limit_next = period_limit;
    buzzer_level_next = buzzer_level;
    accepted          = 1'b0;
    if (cmd.func == FUNC_START) begin
      if (phase == PH_IDLE && count_t != '0) begin
        buzzer_level_next = 1'b1;
        tick_counter_next = '0;
        cycles_left_next  = count_t;
        on_limit_next     = on_t;
        period_limit_next = {1'b0, on_t} + {1'b0, off_t};
        phase_next        = PH_ON;
        accepted          = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_ON: begin
          tick_counter_next = counter_inc;
          if (counter_inc >= {1'b0, on_limit}) begin
            buzzer_level_next = 1'b0;
            phase_next        = PH_OFF;
          end
        end
        PH_OFF: begin
          tick_counter_next = counter_inc;
          if (counter_inc >= period_limit) begin
            tick_counter_next = '0;
            if (cycles_left > TIME_WIDTH'(1)) begin
              cycles_left_next  = cycles_left - 1'b1;
              phase_next        = PH_ON;
              buzzer_level_next = 1'b1;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
          // unused phase code falls back to idle, buzzer off
          buzzer_level_next = 1'b0;
          phase_next        = PH_IDLE;
        end
      endcase
    end
  end

  assign stat.buzzer_on      = buzzer_level_next;
  assign stat.busy_res       = (phase_next != PH_IDLE);
  assign stat.start_accepted = accepted;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= '0;
      cycles_left  <= '0;
      on_limit     <= '0;
      period_limit <= '0;
      buzzer_level <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      cycles_left  <= cycles_left_next;
      on_limit     <= on_limit_next;
      period_limit <= period_limit_next;
      buzzer_level <= buzzer_level_next;
    end
  end

endmodule

### sv/beep_pattern_generator.sv
// top level: input register, pattern timer, result register
// a result passes through the input register and then the result register
// throughput: one item per cycle while the result side does not stall; set by the single timer update per cycle
// the timer state advances when the held item moves into the result register
// reset (rst, synchronous): timer idle with buzzer off, both registers empty
module beep_pattern_generator #(
  parameter int TIME_WIDTH = bpg_pkg::TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  bpg_pkg::bpg_cmd_t  cmd,
  output logic               stat_valid,
  input  logic               stat_stall,
  output bpg_pkg::bpg_stat_t stat
);
  import bpg_pkg::*;

  // input register
  logic      cmd_held_valid;
  bpg_cmd_t  cmd_held;

  // result of the held item, from the timer
  bpg_stat_t stat_calc;

  logic      stat_load;   // result register can take a new result
  logic      advance;     // held item moves on, timer state updates
  logic      cmd_take;    // transfer on the command side

  assign stat_load = !stat_valid || !stat_stall;
  assign advance   = cmd_held_valid && stat_load;
  assign cmd_stall = cmd_held_valid && !stat_load;
  assign cmd_take  = cmd_valid && !cmd_stall;

  bpg_timer #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_timer (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd_held),
    .stat (stat_calc)
  );

  // input register: refills in the same cycle the held item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held_valid <= 1'b0;
    end else if (cmd_take) begin
      cmd_held_valid <= 1'b1;
    end else if (advance) begin
      cmd_held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_held <= cmd;
    end
  end

  // result register: holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (stat_load) begin
      stat_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stat <= stat_calc;
    end
  end

endmodule

### tb/tb_top.sv
// self-checking testbench for the beep pattern generator
`timescale 1ns / 1ps

module tb_top;
  import bpg_pkg::*;

  localparam int TW        = TIME_WIDTH_DEF;
  localparam int MAX_CYC   = 3_000_000;
  localparam int N_RANDOM  = 120;       // random items per idling phase

  // timer phases as the block encodes them; the spare code is never reached
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2,
    PH_SPARE = 2'd3
  } timer_phase_t;

  typedef struct packed {
    timer_phase_t  phase;
    logic [TW:0]   tick_cnt;
    logic [TW-1:0] cycles_left;
    logic [TW-1:0] on_lim;
    logic [TW:0]   period_lim;
    logic          buzzer;
  } timer_state_t;

  // one row of the directed table: a command and, where obvious, its status
  typedef struct packed {
    logic          func;
    logic [TW-1:0] on_t;
    logic [TW-1:0] off_t;
    logic [TW-1:0] count;
    logic          quoted;
    logic [2:0]    status;    // {buzzer_on, busy_res, start_accepted}
  } dir_row_t;

  typedef struct packed {
    logic      quoted;
    bpg_stat_t status;
  } quoted_status_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  bpg_cmd_t  cmd = '0;
  logic      stat_valid;
  logic      stat_stall = 1'b0;
  bpg_stat_t stat;

  timer_state_t   model_state;        // advanced on each accepted command
  timer_state_t   plan_state;         // advanced as commands are queued up
  bpg_stat_t      expected_status_q[$];
  quoted_status_t quoted_status_q[$];
  int             n_errors = 0;
  int             cycle_cnt = 0;
  int             gap_pct = 0;
  int             stall_pct = 0;

  // directed part: reset state, refused starts, zero on length, zero off
  // length, ignored fields on ticks, and starts with all-ones fields
  dir_row_t dir_rows [0:22] = '{
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b000}, // after reset
    '{FUNC_START, 16'd5,     16'd5,     16'd0,     1'b1, 3'b000}, // zero count
    '{FUNC_START, 16'd2,     16'd1,     16'd1,     1'b1, 3'b111},
    '{FUNC_START, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 3'b110}, // start while busy
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b110},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b010}, // on phase done
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b000}, // last cycle done
    '{FUNC_START, 16'd0,     16'd0,     16'd2,     1'b1, 3'b111},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b010}, // zero on length
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b110}, // second repetition
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b010},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b000},
    '{FUNC_START, 16'd3,     16'd0,     16'd1,     1'b1, 3'b111}, // zero off length
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b0, 3'b000},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b0, 3'b000},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b010},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b1, 3'b000}, // counter past sum
    '{FUNC_START, 16'hFFFF,  16'hFFFF,  16'd0,     1'b1, 3'b000}, // zero count, max len
    '{FUNC_TICK,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 3'b000}, // tick ignores fields
    '{FUNC_START, 16'd1,     16'd1,     16'd1,     1'b0, 3'b000},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b0, 3'b000},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b0, 3'b000},
    '{FUNC_TICK,  16'd0,     16'd0,     16'd0,     1'b0, 3'b000}
  };

  beep_pattern_generator uut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .stat_valid (stat_valid),
    .stat_stall (stat_stall),
    .stat       (stat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timer behavior: one command in, new state and status out
  function automatic bpg_stat_t advance_timer(inout timer_state_t s, input bpg_cmd_t c);
    bpg_stat_t r;
    r.start_accepted = 1'b0;
    if (c.func == FUNC_START) begin
      // a start only takes effect from idle with a nonzero count
      if (s.phase == PH_IDLE && c.repeat_count != '0) begin
        s.buzzer      = 1'b1;
        s.tick_cnt    = '0;
        s.cycles_left = c.repeat_count;
        s.on_lim      = c.on_ticks;
        // period kept one bit wider so on+off never wraps
        s.period_lim  = {1'b0, c.on_ticks} + {1'b0, c.off_ticks};
        s.phase       = PH_ON;
        r.start_accepted = 1'b1;
      end
    end else begin
      case (s.phase)
        PH_IDLE: ;
        PH_ON: begin
          s.tick_cnt = s.tick_cnt + 1'b1;
          if (s.tick_cnt >= {1'b0, s.on_lim}) begin
            s.buzzer = 1'b0;
            s.phase  = PH_OFF;
          end
        end
        PH_OFF: begin
          s.tick_cnt = s.tick_cnt + 1'b1;
          if (s.tick_cnt >= s.period_lim) begin
            s.tick_cnt = '0;
            if (s.cycles_left > 1) begin
              s.cycles_left = s.cycles_left - 1'b1;
              s.phase       = PH_ON;
              s.buzzer      = 1'b1;
            end else begin
              s.phase = PH_IDLE;
            end
          end
        end
        default: begin
          s.buzzer = 1'b0;
          s.phase  = PH_IDLE;
        end
      endcase
    end
    r.buzzer_on = s.buzzer;
    r.busy_res  = (s.phase != PH_IDLE);
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  // with valid left high, so back-to-back commands need no extra assignment
  task automatic send_cmd(input bpg_cmd_t c, input logic quoted, input bpg_stat_t status);
    quoted_status_t qs;
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    qs.quoted = quoted;
    qs.status = status;
    quoted_status_q.push_back(qs);
    void'(advance_timer(plan_state, c));
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // hold off the sender until every status has come back
  task automatic drain_status;
    cmd_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(negedge clk);
  endtask

  // mostly well-formed patterns with short lengths, plus refused starts
  // carrying random full-width fields and ticks while idle
  task automatic run_random(input int n_items);
    bpg_cmd_t c;
    int       r;
    for (int i = 0; i < n_items; i++) begin
      r              = $urandom_range(99);
      c.func         = FUNC_TICK;
      c.on_ticks     = TW'($urandom);
      c.off_ticks    = TW'($urandom);
      c.repeat_count = TW'($urandom);
      if (plan_state.phase != PH_IDLE) begin
        if (r < 8) c.func = FUNC_START;     // refused: pattern running
      end else if (r < 70) begin
        c.func         = FUNC_START;
        c.on_ticks     = TW'($urandom_range(5));
        c.off_ticks    = TW'($urandom_range(5));
        c.repeat_count = TW'($urandom_range(3, 1));
      end else if (r < 82) begin
        c.func         = FUNC_START;
        c.repeat_count = '0;                // refused: zero count
      end
      send_cmd(c, 1'b0, '0);
    end
  endtask

  // run the pattern out with ticks only
  task automatic tick_until_idle;
    bpg_cmd_t c;
    c      = '0;
    c.func = FUNC_TICK;
    while (plan_state.phase != PH_IDLE) send_cmd(c, 1'b0, '0);
  endtask

  // receiver stall, redrawn every cycle
  always @(negedge clk) stat_stall <= ($urandom_range(99) < stall_pct);

  // predict on each command transfer, check on each status transfer
  always @(posedge clk) begin
    bpg_stat_t      want;
    quoted_status_t qs;
    if (!rst) begin
      if (stat_valid && !stat_stall) begin
        if (expected_status_q.size() == 0) begin
          n_errors++;
          $display("%0t: status transfer with none expected, got %b/%b/%b", $time,
                   stat.buzzer_on, stat.busy_res, stat.start_accepted);
        end else begin
          want = expected_status_q.pop_front();
          if (stat.buzzer_on !== want.buzzer_on || stat.busy_res !== want.busy_res ||
              stat.start_accepted !== want.start_accepted) begin
            n_errors++;
            $display("%0t: status mismatch (buzzer/busy/accepted) %s %b/%b/%b got %b/%b/%b",
                     $time, "expected", want.buzzer_on, want.busy_res, want.start_accepted,
                     stat.buzzer_on, stat.busy_res, stat.start_accepted);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want = advance_timer(model_state, cmd);
        qs   = quoted_status_q.pop_front();
        expected_status_q.push_back(qs.quoted ? qs.status : want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYC) begin
      $display("beep_pattern_generator verification failed");
      $finish;
    end
  end

  initial begin
    bpg_cmd_t c;
    model_state = '0;
    plan_state  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls heavily
    gap_pct   = 21;
    stall_pct = 73;
    foreach (dir_rows[i]) begin
      c.func         = dir_rows[i].func;
      c.on_ticks     = dir_rows[i].on_t;
      c.off_ticks    = dir_rows[i].off_t;
      c.repeat_count = dir_rows[i].count;
      send_cmd(c, dir_rows[i].quoted, bpg_stat_t'(dir_rows[i].status));
    end
    run_random(N_RANDOM);

    // swap the idling rates
    drain_status();
    gap_pct   = 73;
    stall_pct = 21;
    run_random(N_RANDOM);

    // full rate on both sides
    drain_status();
    gap_pct   = 0;
    stall_pct = 0;
    run_random(N_RANDOM);

    // largest repeat count with an on+off sum that needs the extra period
    // bit; ticks past the on phase show the period did not wrap to zero,
    // and the pattern is left running
    tick_until_idle();
    c              = '0;
    c.func         = FUNC_START;
    c.on_ticks     = 16'd1;
    c.off_ticks    = '1;
    c.repeat_count = '1;
    send_cmd(c, 1'b0, '0);
    c.func         = FUNC_TICK;
    repeat (6) send_cmd(c, 1'b0, '0);

    drain_status();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("beep_pattern_generator verification clean");
    end else begin
      $display("beep_pattern_generator verification failed");
    end
    $finish;
  end

endmodule
